// ===== rtl/core/rsmf_pkg.sv =====
// Package for the range scan median filter: sizes and transfer payload types.
package rsmf_pkg;

	// Half width of the median window.
	localparam int unsigned RADIUS = 2;

	// Window length, and the index widths that follow from it.
	localparam int unsigned WIN   = 2 * RADIUS + 1;
	localparam int unsigned POS_W = $clog2(WIN);
	localparam int unsigned IDX_W = $clog2(RADIUS + 1);

	// Payload field widths.
	localparam int unsigned RANGE_W = 16;
	localparam int unsigned ANGLE_W = 16;

	// One incoming beam.
	typedef struct packed {
		logic [RANGE_W-1:0]        range_sample;
		logic signed [ANGLE_W-1:0] beam_angle;
		logic                      scan_end;
	} sample_t;

	// One filtered beam.
	typedef struct packed {
		logic [RANGE_W-1:0]        filtered_range;
		logic signed [ANGLE_W-1:0] angle_out;
		logic                      last_of_scan;
	} result_t;

endpackage

// ===== rtl/core/range_scan_median_filter.sv =====
// Range scan median filter: sliding window median over the beams of one scan.
//
//  Channel   Handshake                      Payload                 Per transfer
//  sample    sample_valid / sample_ready    rsmf_pkg::sample_t      one beam in
//  result    result_valid / result_ready    rsmf_pkg::result_t      one beam out
//
// A beam that ends no scan leaves the emission stage as soon as its result, if
// any, is emitted, so a steady stream runs at one beam per cycle when the result
// side does not stall. A beam that ends a scan releases up to RADIUS+1 results,
// one per cycle from the emission stage while the result side does not stall, and
// holds sample_ready low until the cycle in which the last of them goes into the
// output register. A taken beam's results pass from the emission stage into the
// output register in order. Reset clears the window, the position count and both
// pipeline valid bits at once; there is no clearing pass.
module range_scan_median_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  rsmf_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_ready,
	output rsmf_pkg::result_t result
);

	// Window storage: the newest beam sits in the highest entry.
	logic [rsmf_pkg::RANGE_W-1:0]        range_win_q [rsmf_pkg::WIN];
	logic signed [rsmf_pkg::ANGLE_W-1:0] angle_win_q [rsmf_pkg::WIN];
	logic [rsmf_pkg::POS_W-1:0]          scan_pos_q;

	// Emission stage: the beam last taken and how far its results have gone.
	logic                       valid_s1;
	logic                       end_s1;
	logic [rsmf_pkg::POS_W-1:0] cnt_s1;
	logic [rsmf_pkg::IDX_W-1:0] idx_s1;

	// Output register.
	logic              result_valid_q;
	rsmf_pkg::result_t result_q;

	// Stage control.
	logic                          accept;
	logic                          out_free;
	logic                          has_out;
	logic                          emit;
	logic                          last_emit;
	logic                          done;
	logic                          full_win;
	logic                          use_med;
	logic [rsmf_pkg::IDX_W-1:0]    back_c;
	logic [rsmf_pkg::IDX_W-1:0]    last_idx_c;
	logic [rsmf_pkg::IDX_W-1:0]    dist_c;
	logic [rsmf_pkg::POS_W-1:0]    pos_c;
	logic [rsmf_pkg::POS_W-1:0]    rank_c [rsmf_pkg::WIN];
	logic [rsmf_pkg::RANGE_W-1:0]  median_c;
	rsmf_pkg::result_t             result_c;

	// Handshake on both sides.
	assign out_free     = !result_valid_q || result_ready;
	assign accept       = sample_valid && sample_ready;
	assign sample_ready = !valid_s1 || done;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Decide which window entry the next result of the held beam comes from.
	always_comb begin
		full_win   = (cnt_s1 == rsmf_pkg::POS_W'(2 * rsmf_pkg::RADIUS));
		back_c     = (cnt_s1 >= rsmf_pkg::POS_W'(rsmf_pkg::RADIUS)) ?
			rsmf_pkg::IDX_W'(rsmf_pkg::RADIUS) : rsmf_pkg::IDX_W'(cnt_s1);
		has_out    = end_s1 || (cnt_s1 >= rsmf_pkg::POS_W'(rsmf_pkg::RADIUS));
		last_idx_c = end_s1 ? back_c : '0;
		dist_c     = end_s1 ? (back_c - idx_s1) : rsmf_pkg::IDX_W'(rsmf_pkg::RADIUS);
		pos_c      = rsmf_pkg::POS_W'(rsmf_pkg::WIN - 1) - rsmf_pkg::POS_W'(dist_c);
		use_med    = full_win && (dist_c == rsmf_pkg::IDX_W'(rsmf_pkg::RADIUS));
		last_emit  = (idx_s1 == last_idx_c);
		emit       = valid_s1 && has_out && out_free;
		done       = valid_s1 && (!has_out || (emit && last_emit));
	end

	// Rank of each window entry; equal values are ordered by position.
	always_comb begin
		for (int i = 0; i < rsmf_pkg::WIN; i++) begin
			rank_c[i] = '0;
			for (int j = 0; j < rsmf_pkg::WIN; j++) begin
				if (j != i) begin
					if ((range_win_q[j] < range_win_q[i]) ||
					    ((range_win_q[j] == range_win_q[i]) && (j < i))) begin
						rank_c[i] = rank_c[i] + rsmf_pkg::POS_W'(1);
					end
				end
			end
		end
	end

	// The entry whose rank is RADIUS is the median.
	always_comb begin
		median_c = '0;
		for (int i = 0; i < rsmf_pkg::WIN; i++) begin
			if (rank_c[i] == rsmf_pkg::POS_W'(rsmf_pkg::RADIUS)) begin
				median_c = range_win_q[i];
			end
		end
	end

	// Assemble the next result.
	always_comb begin
		result_c.filtered_range = use_med ? median_c : range_win_q[pos_c];
		result_c.angle_out      = angle_win_q[pos_c];
		result_c.last_of_scan   = end_s1 && last_emit;
	end

	// Window shift and scan position count, advanced on each sample transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rsmf_pkg::WIN; i++) begin
				range_win_q[i] <= '0;
				angle_win_q[i] <= '0;
			end
			scan_pos_q <= '0;
		end else if (accept) begin
			for (int i = 0; i < rsmf_pkg::WIN - 1; i++) begin
				range_win_q[i] <= range_win_q[i+1];
				angle_win_q[i] <= angle_win_q[i+1];
			end
			range_win_q[rsmf_pkg::WIN-1] <= sample.range_sample;
			angle_win_q[rsmf_pkg::WIN-1] <= sample.beam_angle;
			if (sample.scan_end) begin
				scan_pos_q <= '0;
			end else if (scan_pos_q != rsmf_pkg::POS_W'(2 * rsmf_pkg::RADIUS)) begin
				scan_pos_q <= scan_pos_q + rsmf_pkg::POS_W'(1);
			end
		end
	end

	// Emission stage: holds the beam until all of its results are out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			end_s1   <= 1'b0;
			cnt_s1   <= '0;
			idx_s1   <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			end_s1   <= sample.scan_end;
			cnt_s1   <= scan_pos_q;
			idx_s1   <= '0;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			idx_s1 <= idx_s1 + rsmf_pkg::IDX_W'(1);
		end
	end

	// Output register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= result_c;
		end
	end

endmodule

// ===== rtl/core/rsmf_checker.sv =====
// Port checker for the range scan median filter, bound to the top level.
module rsmf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_ready,
	input rsmf_pkg::sample_t sample,
	input logic              result_valid,
	input logic              result_ready,
	input rsmf_pkg::result_t result
);

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// Reset empties the output register.
	assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	// A new result on an idle output follows a sample transfer through the pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
		else $error("result appeared without a preceding sample transfer");

endmodule

bind range_scan_median_filter rsmf_checker u_rsmf_checker (.*);
